[design/sorted_software_timer_queue_assert.svh]
// Assertion macros used by the timer queue top level.
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sstq_pkg.sv]
// Shared constants and codes for the sorted timer queue.
`timescale 1ns / 1ps
package sstq_pkg;
	localparam int SLOTS     = 32;
	localparam int TAG_BITS  = 16;
	localparam int WORD_BITS = 32;
	localparam int SLOT_BITS = 5;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam logic [WORD_BITS-1:0] FREQ_RESET = 32'd62500000;

	typedef enum logic [1:0] {
		OP_ADD_SEC  = 2'd0,
		OP_ADD_RATE = 2'd1,
		OP_TICK     = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_ZERO_RATE = 2'd2,
		ST_EXPIRED   = 2'd3
	} status_t;
endpackage

[design/sorted_software_timer_queue.sv]
// Top level: sorted timer slot pool with add/tick sequencer.
// Add after seconds: multiply (S_MUL), saturate (S_SAT), insertion walk, then output wait.
// Add at rate: the bit-serial divider, then the insertion walk.
// Tick: a subtract pass over the active entries, an emit step per expired item, then a
// compaction pass over the kept entries. One item in flight at a time; in_ready only while idle.
// Reset (async, active low): all slots free, queue empty, frequency 62500000.
`timescale 1ns / 1ps
`include "sorted_software_timer_queue_assert.svh"
module sorted_software_timer_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sstq_pkg::WORD_BITS-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic [sstq_pkg::WORD_BITS-1:0] amount,
	input  logic [sstq_pkg::TAG_BITS-1:0]  tag,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [sstq_pkg::SLOT_BITS-1:0] slot,
	output logic [sstq_pkg::TAG_BITS-1:0]  fired_tag,
	output logic                           last
);
	import sstq_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL  = 9'b000000010,
		S_SAT  = 9'b000000100,
		S_DIV  = 9'b000001000,
		S_INS  = 9'b000010000,
		S_RESP = 9'b000100000,
		S_SUB  = 9'b001000000,
		S_EMIT = 9'b010000000,
		S_COMP = 9'b100000000
	} state_t;

	state_t state_q;

	logic [WORD_BITS-1:0]   freq_q;
	logic [SLOTS-1:0]       free_map_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;     // walk pointer (insert position, sub/emit/compact)
	logic [CNT_W-1:0]       nz_q;      // zero entries found by the subtract pass
	logic [WORD_BITS-1:0]   amount_q;
	logic [TAG_BITS-1:0]    tag_q;
	logic [IDX_W-1:0]       new_slot_q;
	logic [WORD_BITS-1:0]   delay_q;
	logic [2*WORD_BITS-1:0] prod_q;

	// Queue kept by sorted position, soonest first.
	logic [WORD_BITS-1:0] pos_rem_q  [SLOTS];
	logic [TAG_BITS-1:0]  pos_tag_q  [SLOTS];
	logic [IDX_W-1:0]     pos_slot_q [SLOTS];

	// Output register.
	logic                 out_valid_q;
	status_t              status_q;
	logic [IDX_W-1:0]     slot_q;
	logic [TAG_BITS-1:0]  fired_tag_q;
	logic                 last_q;

	logic                 in_acc, out_acc;
	logic [IDX_W-1:0]     lo_slot;
	logic [IDX_W-1:0]     rd_idx;
	logic [WORD_BITS-1:0] rd_rem;
	logic [TAG_BITS-1:0]  rd_tag;
	logic [IDX_W-1:0]     rd_slot;
	logic [WORD_BITS-1:0] sub_rem;
	logic [CNT_W-1:0]     idx_dec, comp_dst;
	logic                 div_start, div_done;
	logic [WORD_BITS-1:0] div_quo;
	opcode_t              op_in;

	assign op_in     = opcode_t'(opcode);
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid_q && out_ready;
	assign idx_dec   = idx_q - 1'b1;
	assign comp_dst  = idx_q - nz_q;

	// Lowest free slot.
	always_comb begin
		lo_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_map_q[i]) lo_slot = IDX_W'(i);
		end
	end

	// Single read port into the position arrays.
	always_comb begin
		if (state_q == S_INS) rd_idx = idx_dec[IDX_W-1:0];
		else rd_idx = idx_q[IDX_W-1:0];
	end
	assign rd_rem  = pos_rem_q[rd_idx];
	assign rd_tag  = pos_tag_q[rd_idx];
	assign rd_slot = pos_slot_q[rd_idx];
	assign sub_rem = (amount_q > rd_rem) ? '0 : rd_rem - amount_q;

	assign div_start = in_acc && op_in == OP_ADD_RATE && count_q != CNT_W'(SLOTS)
		&& amount != '0;

	sstq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (freq_q),
		.divisor  (amount),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			freq_q <= cfg_data;
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_map_q  <= '1;
			count_q     <= '0;
			idx_q       <= '0;
			nz_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (op_in)
							OP_ADD_SEC, OP_ADD_RATE: begin
								if (count_q == CNT_W'(SLOTS) || free_map_q == '0) begin
									out_valid_q <= 1'b1;
									state_q     <= S_RESP;
								end else if (op_in == OP_ADD_RATE && amount == '0) begin
									out_valid_q <= 1'b1;
									state_q     <= S_RESP;
								end else if (op_in == OP_ADD_SEC) begin
									state_q <= S_MUL;
								end else begin
									state_q <= S_DIV;
								end
							end
							OP_TICK: begin
								idx_q   <= '0;
								nz_q    <= '0;
								state_q <= S_SUB;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: state_q <= S_SAT;
				S_SAT: begin
					idx_q   <= count_q;
					state_q <= S_INS;
				end
				S_DIV: begin
					if (div_done) begin
						idx_q   <= count_q;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (idx_q != '0 && rd_rem > delay_q) begin
						idx_q <= idx_dec;
					end else begin
						count_q                <= count_q + 1'b1;
						free_map_q[new_slot_q] <= 1'b0;
						out_valid_q            <= 1'b1;
						state_q                <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_SUB: begin
					if (idx_q != count_q) begin
						if (sub_rem == '0) nz_q <= nz_q + 1'b1;
						idx_q <= idx_q + 1'b1;
					end else if (nz_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_valid_q) begin
						if (out_ready) begin
							out_valid_q <= 1'b0;
							if (idx_q == nz_q) state_q <= S_COMP;
						end
					end else begin
						free_map_q[rd_slot] <= 1'b1;
						out_valid_q         <= 1'b1;
						idx_q               <= idx_q + 1'b1;
					end
				end
				S_COMP: begin
					if (idx_q != count_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= count_q - nz_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath and queue storage (no reset needed).
	always_ff @(posedge clk) begin
		if (in_acc) begin
			amount_q   <= amount;
			tag_q      <= tag;
			new_slot_q <= lo_slot;
			fired_tag_q <= '0;
			last_q     <= 1'b1;
			slot_q     <= '0;
			if (count_q == CNT_W'(SLOTS) || free_map_q == '0) status_q <= ST_FULL;
			else status_q <= ST_ZERO_RATE;
		end
		case (state_q)
			S_MUL: prod_q <= amount_q * freq_q;
			S_SAT: delay_q <= (prod_q[2*WORD_BITS-1:WORD_BITS] != '0) ? '1
				: prod_q[WORD_BITS-1:0];
			S_DIV: if (div_done) delay_q <= div_quo;
			S_INS: begin
				if (idx_q != '0 && rd_rem > delay_q) begin
					pos_rem_q[idx_q[IDX_W-1:0]]  <= rd_rem;
					pos_tag_q[idx_q[IDX_W-1:0]]  <= rd_tag;
					pos_slot_q[idx_q[IDX_W-1:0]] <= rd_slot;
				end else begin
					pos_rem_q[idx_q[IDX_W-1:0]]  <= delay_q;
					pos_tag_q[idx_q[IDX_W-1:0]]  <= tag_q;
					pos_slot_q[idx_q[IDX_W-1:0]] <= new_slot_q;
					status_q                     <= ST_ACCEPTED;
					slot_q                       <= new_slot_q;
				end
			end
			S_SUB: if (idx_q != count_q) pos_rem_q[idx_q[IDX_W-1:0]] <= sub_rem;
			S_EMIT: begin
				if (!out_valid_q) begin
					status_q    <= ST_EXPIRED;
					slot_q      <= rd_slot;
					fired_tag_q <= rd_tag;
					last_q      <= (idx_q + 1'b1 == nz_q);
				end
			end
			S_COMP: begin
				if (idx_q != count_q) begin
					pos_rem_q[comp_dst[IDX_W-1:0]]  <= rd_rem;
					pos_tag_q[comp_dst[IDX_W-1:0]]  <= rd_tag;
					pos_slot_q[comp_dst[IDX_W-1:0]] <= rd_slot;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = SLOT_BITS'(slot_q);
	assign fired_tag = fired_tag_q;
	assign last      = last_q;

	// slots freed during emit are only taken off the count at the end of compaction
	`SSTQ_ASSERT_NOW(a_pool_balance, state_q == S_IDLE,
		($countones(free_map_q) + count_q) == SLOTS,
		"free slots and queued entries do not add up")
	`SSTQ_ASSERT_NOW(a_out_state, out_valid_q, state_q == S_RESP || state_q == S_EMIT,
		"result shown outside a result state")
	`SSTQ_ASSERT_NOW(a_count_max, 1'b1, count_q <= CNT_W'(SLOTS),
		"queue count above pool size")
	`SSTQ_ASSERT_NEXT(a_hold, out_valid_q && !out_ready, out_valid_q && $stable(slot_q),
		"stalled result changed")
endmodule

[design/sstq_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sstq_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [sstq_pkg::WORD_BITS-1:0] dividend,
	input  logic [sstq_pkg::WORD_BITS-1:0] divisor,
	output logic                           done,
	output logic [sstq_pkg::WORD_BITS-1:0] quotient
);
	import sstq_pkg::*;
	localparam int DIV_CNT_W = $clog2(WORD_BITS);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0] quo_q, dvs_q;
	logic [WORD_BITS:0]   rem_sh, rem_sub;
	logic                 fits;

	assign rem_sh  = {rem_q, quo_q[WORD_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so 32 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
			quo_q <= {quo_q[WORD_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the sorted software timer queue.
`timescale 1ns / 1ps
module tb;
	import sstq_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE       = 300;   // covers the longest tick walk plus the divider

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] amt;
		logic [15:0] tg;
	} timer_req_t;

	typedef struct packed {
		status_t     st;
		logic [4:0]  sl;
		logic [15:0] ftag;
		logic        lst;
	} timer_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_NONE;
	logic [31:0] amount = '0;
	logic [15:0] tag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [4:0] slot;
	logic [15:0] fired_tag;
	logic last;

	sorted_software_timer_queue dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .amount(amount), .tag(tag),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot(slot), .fired_tag(fired_tag), .last(last)
	);

	always #6 clk = ~clk;

	// Shadow of the timer pool, kept in step with accepted items.
	logic [31:0] sh_freq;
	logic [31:0] sh_free;
	logic [31:0] sh_remain [SLOTS];
	logic [15:0] sh_tag [SLOTS];
	logic [4:0]  sh_order [SLOTS];
	int          sh_count;

	timer_req_t  req_q [$];    // items waiting for the driver
	timer_resp_t due_q [$];    // results the block still owes

	int  errors = 0;
	int  n_items = 0;
	int  n_results = 0;
	int  n_expired = 0;
	int  n_full = 0;
	int  n_cfg = 0;
	int  cycles = 0;
	bit  in_taken = 1'b0;
	bit  hold_go = 1'b0;
	bit  held = 1'b0;
	int  hold_cnt = 0;
	logic [7:0] rdy_pat = 8'hff;
	int  burst_left = 4;
	int  gap_left = 0;

	function automatic void push_resp(status_t st, logic [4:0] sl, logic [15:0] ft, logic l);
		timer_resp_t r;
		r.st = st;
		r.sl = sl;
		r.ftag = ft;
		r.lst = l;
		due_q.push_back(r);
	endfunction

	// Apply one accepted item to the shadow pool and queue its results.
	function automatic void timer_step(timer_req_t rq);
		logic [63:0] prod;
		logic [31:0] dly;
		int s;
		int pos;
		int fired;
		case (rq.op)
			OP_ADD_SEC, OP_ADD_RATE: begin
				if (sh_free == '0 || sh_count >= SLOTS) begin
					push_resp(ST_FULL, '0, '0, 1'b1);
					n_full++;
				end else if (rq.op == OP_ADD_RATE && rq.amt == '0) begin
					push_resp(ST_ZERO_RATE, '0, '0, 1'b1);
				end else begin
					s = 0;
					while (!sh_free[s]) s++;
					if (rq.op == OP_ADD_SEC) begin
						prod = 64'(rq.amt) * 64'(sh_freq);
						dly = (prod > 64'hffff_ffff) ? 32'hffff_ffff : prod[31:0];
					end else begin
						dly = sh_freq / rq.amt;
					end
					sh_free[s] = 1'b0;
					sh_remain[s] = dly;
					sh_tag[s] = rq.tg;
					// insert after every equal delay
					pos = 0;
					while (pos < sh_count && !(dly < sh_remain[sh_order[pos]])) pos++;
					for (int i = sh_count; i > pos; i--) sh_order[i] = sh_order[i-1];
					sh_order[pos] = 5'(s);
					sh_count++;
					push_resp(ST_ACCEPTED, 5'(s), '0, 1'b1);
				end
			end
			OP_TICK: begin
				for (int i = 0; i < sh_count; i++) begin
					s = sh_order[i];
					sh_remain[s] = (rq.amt > sh_remain[s]) ? '0 : sh_remain[s] - rq.amt;
				end
				fired = 0;
				while (fired < sh_count && sh_remain[sh_order[fired]] == '0) begin
					s = sh_order[fired];
					push_resp(ST_EXPIRED, 5'(s), sh_tag[s], fired == sh_count - 1 ||
						sh_remain[sh_order[fired+1]] != '0);
					sh_free[s] = 1'b1;
					fired++;
					n_expired++;
				end
				for (int i = fired; i < sh_count; i++) sh_order[i-fired] = sh_order[i];
				sh_count -= fired;
			end
			default: ;   // unused opcode leaves the pool alone
		endcase
	endfunction

	// Sender: bursts of random length, random gaps, payload held until taken.
	always @(negedge clk) begin
		timer_req_t rq;
		if (in_valid && !in_taken) begin
			// keep offering
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (req_q.size() > 0) begin
			rq = req_q.pop_front();
			in_valid <= 1'b1;
			opcode <= rq.op;
			amount <= rq.amt;
			tag <= rq.tg;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else begin
			in_valid <= 1'b0;
		end
		in_taken = 1'b0;
	end

	// Receiver: rotating stall pattern, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_go && !held) begin
			held = 1'b1;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			rdy_pat = {rdy_pat[6:0], rdy_pat[7]};
			out_ready <= rdy_pat[0];
		end
	end

	// Monitor: predict on input accept, check on output accept.
	always @(posedge clk) begin
		timer_req_t rq;
		timer_resp_t want;
		if (arst_n && in_valid && in_ready) begin
			rq.op = opcode;
			rq.amt = amount;
			rq.tg = tag;
			timer_step(rq);
			in_taken = 1'b1;
			n_items++;
		end
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (due_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d tag=%h last=%b",
					$time, status, slot, fired_tag, last);
				errors++;
			end else begin
				want = due_q.pop_front();
				if (status !== want.st || slot !== want.sl || fired_tag !== want.ftag ||
						last !== want.lst) begin
					$display("%0t: mismatch expected status=%0d slot=%0d tag=%h last=%b",
						$time, want.st, want.sl, want.ftag, want.lst);
					$display("%0t:          actual   status=%0d slot=%0d tag=%h last=%b",
						$time, status, slot, fired_tag, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, due_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic timer_req_t mk(opcode_t op, logic [31:0] amt, logic [15:0] tg);
		timer_req_t r;
		r.op = op;
		r.amt = amt;
		r.tg = tg;
		return r;
	endfunction

	// Mostly adds and ticks scaled to the current frequency, some noise.
	function automatic timer_req_t rand_req();
		int pick;
		logic [31:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			a = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
			return mk(OP_ADD_SEC, a, 16'($urandom));
		end else if (pick < 62) begin
			case ($urandom_range(0, 4))
				0: a = 0;
				1: a = $urandom;
				default: a = $urandom_range(1, 16);
			endcase
			return mk(OP_ADD_RATE, a, 16'($urandom));
		end else if (pick < 95) begin
			case ($urandom_range(0, 5))
				0: a = 0;
				1: a = $urandom;
				2: a = 32'hffff_ffff;
				default: a = $urandom_range(0, (sh_freq > 32'h7fff_ffff) ?
					32'h7fff_ffff : sh_freq);
			endcase
			return mk(OP_TICK, a, 16'($urandom));
		end
		return mk(OP_NONE, $urandom, 16'($urandom));
	endfunction

	// Wait until the block has drained; then let a possibly silent tick finish.
	task automatic drain();
		while (req_q.size() > 0 || in_valid || due_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_freq(logic [31:0] f);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= f;
		do @(posedge clk); while (!cfg_ready);
		sh_freq = f;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] freqs [5];
		sh_freq = FREQ_RESET;
		sh_free = '1;
		sh_count = 0;
		freqs[0] = 32'd1;
		freqs[1] = 32'hffff_ffff;
		freqs[2] = 32'd1000;
		freqs[3] = $urandom;
		freqs[4] = FREQ_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, each opcode, zero rate, saturation, pool full, full flush.
		req_q.push_back(mk(OP_ADD_SEC, 32'd0, 16'h0000));
		req_q.push_back(mk(OP_ADD_SEC, 32'hffff_ffff, 16'hffff));
		req_q.push_back(mk(OP_ADD_RATE, 32'd0, 16'h1234));
		req_q.push_back(mk(OP_ADD_RATE, 32'd1, 16'h5a5a));
		req_q.push_back(mk(OP_ADD_RATE, 32'hffff_ffff, 16'ha5a5));
		req_q.push_back(mk(OP_NONE, 32'hffff_ffff, 16'hffff));
		req_q.push_back(mk(OP_TICK, 32'd0, 16'h0));
		req_q.push_back(mk(OP_TICK, 32'd62_500_000, 16'h0));
		for (int i = 0; i < 31; i++)
			req_q.push_back(mk(OP_ADD_SEC, 32'd1, 16'(i * 16'h0801)));
		req_q.push_back(mk(OP_ADD_SEC, 32'd1, 16'hbeef));
		req_q.push_back(mk(OP_ADD_RATE, 32'd0, 16'hbeef));   // full wins over zero rate
		req_q.push_back(mk(OP_TICK, 32'hffff_ffff, 16'h0));  // every slot fires at once
		drain();

		// Random phases, each at its own frequency; drained before each write.
		for (int ph = 0; ph < 5; ph++) begin
			write_freq(freqs[ph]);
			rdy_pat = (ph == 3) ? 8'hff : 8'($urandom) | 8'h01;
			for (int i = 0; i < 18; i++) req_q.push_back(rand_req());
			if (ph == 1) begin
				// long receiver hold-off while the sender keeps offering
				repeat (20) @(posedge clk);
				hold_go = 1'b1;
			end
			drain();
		end

		$display("Ran %0d items over %0d frequency settings: %0d results checked,",
			n_items, n_cfg, n_results);
		$display("%0d expiries and %0d pool-full answers seen.", n_expired, n_full);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
